// ===== sv/gmcr_pkg.sv =====
// Shared types and constants for the gradient map colour remap block.
`default_nettype none
package gmcr_pkg;

	localparam int REG_SLOTS = 5;
	localparam int CNT_W     = 3;
	localparam int IDX_W     = 3;
	localparam int DATA_W    = 32;

	localparam logic [IDX_W-1:0] CFG_STOP_A = 3'd0;
	localparam logic [IDX_W-1:0] CFG_COUNT  = 3'd5;

	typedef struct packed {
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} pixel_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} result_t;

endpackage
`default_nettype wire

// ===== sv/gradient_map_color_remap.sv =====
// Gradient map colour remap: gray level mapped through a sorted colour ramp.
//
//  channel  | signals                    | notes
//  ---------+----------------------------+------------------------------
//  input    | start, busy, pixel         | transaction when start & !busy
//  result   | done, result               | one-cycle strobe, no back-pressure
//  config   | cfg_we, cfg_index, cfg_data| write only, sorted copy is registered
//
// Six register stages: gray, segment select, three divider stages of three
// quotient bits each, blend. One pixel per clock; done and result leave the blend stage together.
// busy is never raised. Reset clears stops, count and all valid bits.
`default_nettype none
module gradient_map_color_remap #(
	parameter int NUM_STOPS = 5
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire gmcr_pkg::pixel_t              pixel,
	output logic                               done,
	output gmcr_pkg::result_t                  result,
	input  wire logic                          cfg_we,
	input  wire logic [gmcr_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [gmcr_pkg::DATA_W-1:0]   cfg_data
);

	localparam int IW = (NUM_STOPS > 1) ? $clog2(NUM_STOPS) : 1;

	function automatic logic [9:0] dstep(input logic [9:0] rem, input logic [8:0] den);
		logic       ge;
		logic [9:0] r;
		ge = rem >= {1'b0, den};
		r  = ge ? rem - {1'b0, den} : rem;
		return {ge, r[8:0]};
	endfunction

	function automatic logic [7:0] lerp(input logic [7:0] a, input logic [7:0] b,
			input logic [8:0] t);
		logic [17:0] acc;
		acc = 18'(a) * 18'(9'd256 - t) + 18'(b) * 18'(t) + 18'd128;
		return acc[15:8];
	endfunction

	// configuration
	logic [31:0]                 stop_q [gmcr_pkg::REG_SLOTS];
	logic [gmcr_pkg::CNT_W-1:0]  cnt_q;
	logic [31:0]                 srt_q [NUM_STOPS];
	logic [gmcr_pkg::CNT_W-1:0]  n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < gmcr_pkg::REG_SLOTS; i++) stop_q[i] <= '0;
			cnt_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == gmcr_pkg::CFG_COUNT)
				cnt_q <= cfg_data[gmcr_pkg::CNT_W-1:0];
			else if (cfg_index < gmcr_pkg::CFG_COUNT)
				stop_q[cfg_index - gmcr_pkg::CFG_STOP_A] <= cfg_data;
		end
	end

	// stable sort by rank
	logic [gmcr_pkg::CNT_W-1:0]  n_sat;
	logic [31:0]                 srt_d [NUM_STOPS];
	logic [2:0]                  rank [NUM_STOPS];

	always_comb begin
		n_sat = (int'(cnt_q) > NUM_STOPS) ? gmcr_pkg::CNT_W'(NUM_STOPS) : cnt_q;
		for (int i = 0; i < NUM_STOPS; i++) begin
			rank[i] = '0;
			for (int j = 0; j < NUM_STOPS; j++) begin
				if (j != i && j < int'(n_sat) &&
				    (stop_q[j][31:24] < stop_q[i][31:24] ||
				     (stop_q[j][31:24] == stop_q[i][31:24] && j < i)))
					rank[i] = rank[i] + 3'd1;
			end
		end
		for (int k = 0; k < NUM_STOPS; k++) begin
			srt_d[k] = '0;
			for (int i = 0; i < NUM_STOPS; i++)
				if (i < int'(n_sat) && int'(rank[i]) == k) srt_d[k] = srt_d[k] | stop_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_STOPS; k++) srt_q[k] <= '0;
			n_q <= '0;
		end else begin
			for (int k = 0; k < NUM_STOPS; k++) srt_q[k] <= srt_d[k];
			n_q <= n_sat;
		end
	end

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// stage 1: gray
	logic [7:0]  gray_s1;
	logic [23:0] pix_s1;
	logic [15:0] gray_sum;

	assign gray_sum = 16'(16'd77 * 16'(pixel.in_red) + 16'd150 * 16'(pixel.in_green)
		+ 16'd29 * 16'(pixel.in_blue) + 16'd128);

	always_ff @(posedge clk) begin
		gray_s1 <= gray_sum[15:8];
		pix_s1  <= pixel;
	end

	// stage 2: segment select
	logic [23:0] a_d, c_d;
	logic [8:0]  num_d, den_d;
	logic        hit;
	logic [7:0]  p0, tp;
	logic [31:0] tail;
	logic [IW-1:0] tidx;

	always_comb begin
		a_d   = srt_q[0][23:0];
		c_d   = srt_q[0][23:0];
		num_d = '0;
		den_d = '0;
		hit   = 1'b0;
		tidx  = IW'(n_q - 3'd1);
		tail  = srt_q[tidx];
		p0    = srt_q[0][31:24];
		tp    = tail[31:24];
		for (int i = 0; i < NUM_STOPS - 1; i++) begin
			if (!hit && int'(n_q) > i + 1 && gray_s1 >= srt_q[i][31:24] &&
			    gray_s1 < srt_q[i+1][31:24]) begin
				hit   = 1'b1;
				a_d   = srt_q[i][23:0];
				c_d   = srt_q[i+1][23:0];
				num_d = {1'b0, gray_s1 - srt_q[i][31:24]};
				den_d = {1'b0, srt_q[i+1][31:24] - srt_q[i][31:24]};
			end
		end
		if (!hit) begin
			if (gray_s1 >= tp) begin
				a_d   = tail[23:0];
				num_d = {1'b0, gray_s1 - tp};
				den_d = {1'b0, p0} + 9'd255 - {1'b0, tp};
			end else if (gray_s1 < p0) begin
				a_d   = tail[23:0];
				num_d = 9'd255 - {1'b0, tp} + {1'b0, gray_s1};
				den_d = 9'd255 - {1'b0, tp} + {1'b0, p0};
			end
		end
		if (n_q == '0) begin
			a_d   = pix_s1;
			c_d   = pix_s1;
			num_d = '0;
			den_d = '0;
		end
	end

	logic [23:0] a_s2, c_s2;
	logic [8:0]  num_s2, den_s2;

	always_ff @(posedge clk) begin
		a_s2   <= a_d;
		c_s2   <= c_d;
		num_s2 <= num_d;
		den_s2 <= den_d;
	end

	// stages 3 to 5: restoring divider, three bits a stage
	logic [9:0]  st3, st4, st5;
	logic [8:0]  q3_d;
	logic [8:0]  q4_d;
	logic [8:0]  q5_d;
	logic [23:0] a_s3, c_s3, a_s4, c_s4, a_s5, c_s5;
	logic [8:0]  den_s3, den_s4, rem_s3, rem_s4;
	logic [8:0]  q_s3, q_s4, t_s5;
	logic        dz_s3, dz_s4;

	always_comb begin
		q3_d    = '0;
		st3     = dstep({1'b0, num_s2}, den_s2);
		q3_d[8] = st3[9];
		st3     = dstep({st3[8:0], 1'b0}, den_s2);
		q3_d[7] = st3[9];
		st3     = dstep({st3[8:0], 1'b0}, den_s2);
		q3_d[6] = st3[9];
	end

	always_ff @(posedge clk) begin
		a_s3   <= a_s2;
		c_s3   <= c_s2;
		den_s3 <= den_s2;
		dz_s3  <= den_s2 == '0;
		rem_s3 <= st3[8:0];
		q_s3   <= q3_d;
	end

	always_comb begin
		q4_d    = q_s3;
		st4     = dstep({rem_s3, 1'b0}, den_s3);
		q4_d[5] = st4[9];
		st4     = dstep({st4[8:0], 1'b0}, den_s3);
		q4_d[4] = st4[9];
		st4     = dstep({st4[8:0], 1'b0}, den_s3);
		q4_d[3] = st4[9];
	end

	always_ff @(posedge clk) begin
		a_s4   <= a_s3;
		c_s4   <= c_s3;
		den_s4 <= den_s3;
		dz_s4  <= dz_s3;
		rem_s4 <= st4[8:0];
		q_s4   <= q4_d;
	end

	always_comb begin
		q5_d    = q_s4;
		st5     = dstep({rem_s4, 1'b0}, den_s4);
		q5_d[2] = st5[9];
		st5     = dstep({st5[8:0], 1'b0}, den_s4);
		q5_d[1] = st5[9];
		st5     = dstep({st5[8:0], 1'b0}, den_s4);
		q5_d[0] = st5[9];
	end

	always_ff @(posedge clk) begin
		a_s5 <= a_s4;
		c_s5 <= c_s4;
		t_s5 <= dz_s4 ? 9'd0 : q5_d;
	end

	// stage 6: blend
	gmcr_pkg::result_t res_s6;

	always_ff @(posedge clk) begin
		res_s6.out_red   <= lerp(a_s5[23:16], c_s5[23:16], t_s5);
		res_s6.out_green <= lerp(a_s5[15:8],  c_s5[15:8],  t_s5);
		res_s6.out_blue  <= lerp(a_s5[7:0],   c_s5[7:0],   t_s5);
	end

	assign busy   = 1'b0;
	assign done   = v_s6;
	assign result = res_s6;

	// checks
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##6 done) else $error("result strobe missing");
	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> t_s5 <= 9'd256) else $error("ramp fraction out of range");
	a_num_den: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> num_s2 <= den_s2) else $error("numerator exceeds denominator");
	a_cnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		int'(n_q) <= NUM_STOPS) else $error("stop count not saturated");

endmodule
`default_nettype wire

// ===== test/gmcr_checker.sv =====
// Checker for the gradient map colour remap: mirrors config, predicts pixels, compares results.
`timescale 1ns / 1ps
module gmcr_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          busy,
	input  wire gmcr_pkg::pixel_t              pixel,
	input  wire logic                          done,
	input  wire gmcr_pkg::result_t             result,
	input  wire logic                          cfg_we,
	input  wire logic [gmcr_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [gmcr_pkg::DATA_W-1:0]   cfg_data,
	output int                                 fail_count,
	output int                                 pending,
	output int                                 checked
);

	logic [31:0]         stops [gmcr_pkg::REG_SLOTS];
	logic [2:0]          count;
	gmcr_pkg::result_t   expected_pixels [$];

	function automatic logic [7:0] blend(input int unsigned a, input int unsigned b,
		input int unsigned t);
		return 8'((a * (256 - t) + b * t + 128) >> 8);
	endfunction

	function automatic int unsigned ramp_frac(input int unsigned num, input int unsigned den);
		int unsigned t;
		if (den == 0)
			return 0;
		t = (num * 256) / den;
		return (t > 256) ? 256 : t;
	endfunction

	function automatic gmcr_pkg::result_t remap(input gmcr_pkg::pixel_t px);
		logic [31:0] s [5];
		logic [31:0] a, c, v;
		int unsigned n, gray, t, p0, p1, tp, j;
		bit hit;
		gmcr_pkg::result_t r;
		n = (count > 5) ? 5 : count;
		if (n == 0) begin
			r.out_red = px.in_red;
			r.out_green = px.in_green;
			r.out_blue = px.in_blue;
			return r;
		end
		gray = (77 * px.in_red + 150 * px.in_green + 29 * px.in_blue + 128) >> 8;
		for (int i = 0; i < n; i++) begin
			v = stops[i];
			j = i;
			while (j > 0 && s[j-1][31:24] > v[31:24]) begin
				s[j] = s[j-1];
				j--;
			end
			s[j] = v;
		end
		a = s[0];
		c = s[0];
		t = 0;
		hit = 0;
		for (int i = 0; i + 1 < n; i++) begin
			p0 = s[i][31:24];
			p1 = s[i+1][31:24];
			if (!hit && gray >= p0 && gray < p1) begin
				a = s[i];
				c = s[i+1];
				t = ramp_frac(gray - p0, p1 - p0);
				hit = 1;
			end
		end
		if (!hit) begin
			p0 = s[0][31:24];
			tp = s[n-1][31:24];
			if (gray >= tp) begin
				a = s[n-1];
				c = s[0];
				t = ramp_frac(gray - tp, p0 + 255 - tp);
			end else if (gray < p0) begin
				a = s[n-1];
				c = s[0];
				t = ramp_frac(255 - tp + gray, 255 - tp + p0);
			end
		end
		r.out_red = blend(a[23:16], c[23:16], t);
		r.out_green = blend(a[15:8], c[15:8], t);
		r.out_blue = blend(a[7:0], c[7:0], t);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		gmcr_pkg::result_t want;
		if (!arst_n) begin
			for (int i = 0; i < gmcr_pkg::REG_SLOTS; i++)
				stops[i] <= '0;
			count <= '0;
			fail_count <= 0;
			checked <= 0;
			pending <= 0;
			expected_pixels.delete();
		end else begin
			if (done) begin
				if (expected_pixels.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result %h", result);
				end else begin
					want = expected_pixels.pop_front();
					checked <= checked + 1;
					if (want.out_red !== result.out_red || want.out_green !== result.out_green
						|| want.out_blue !== result.out_blue) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: expected %h got %h", want, result);
					end
				end
			end
			if (start && !busy)
				expected_pixels.push_back(remap(pixel));
			pending <= expected_pixels.size();
			if (cfg_we) begin
				if (cfg_index < gmcr_pkg::REG_SLOTS)
					stops[cfg_index] <= cfg_data;
				else if (cfg_index == gmcr_pkg::CFG_COUNT)
					count <= cfg_data[2:0];
			end
		end
	end
endmodule

// ===== test/testbench.sv =====
// Top of the colour remap testbench: clock, reset, config phases and pixel stimulus.
`timescale 1ns / 1ps
module testbench;

	logic clk = 0, arst_n = 0;
	logic start = 0, cfg_we = 0;
	logic busy, done;
	gmcr_pkg::pixel_t pixel = '0;
	gmcr_pkg::result_t result;
	logic [gmcr_pkg::IDX_W-1:0] cfg_index = '0;
	logic [gmcr_pkg::DATA_W-1:0] cfg_data = '0;
	int fail_count, pending, checked;
	int gap_pct;
	int phases;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	gradient_map_color_remap dut (.*);
	gmcr_checker chk (.*);

	task automatic write_reg(input logic [gmcr_pkg::IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic send_pixel(input gmcr_pkg::pixel_t px);
		while ($urandom_range(99) < gap_pct) begin
			@(posedge clk);
			start <= 0;
		end
		@(posedge clk);
		start <= 1;
		pixel <= px;
		while (busy !== 1'b0)
			@(posedge clk);
	endtask

	task automatic drain;
		@(posedge clk);
		start <= 0;
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// random ramp; mode 0 random, 1 extremes, 2 equal positions
	task automatic load_ramp(input int mode, input int cnt);
		logic [31:0] v;
		for (int i = 0; i < gmcr_pkg::REG_SLOTS; i++) begin
			v = $urandom;
			if (mode == 1)
				v[31:24] = (i % 2) ? 8'hFF : 8'h00;
			else if (mode == 2)
				v[31:24] = 8'd128;
			write_reg(gmcr_pkg::CFG_STOP_A + gmcr_pkg::IDX_W'(i), v);
		end
		write_reg(gmcr_pkg::CFG_COUNT, 32'(cnt));
	endtask

	task automatic random_pixels(input int k);
		gmcr_pkg::pixel_t px;
		for (int i = 0; i < k; i++) begin
			px = 24'($urandom);
			send_pixel(px);
		end
	endtask

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		gap_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		// directed: pass-through, single stop, extremes
		send_pixel('0);
		send_pixel('1);
		send_pixel(24'hFF0000);
		send_pixel(24'h00FF00);
		send_pixel(24'h0000FF);
		drain();
		load_ramp(0, 1);
		send_pixel('0);
		send_pixel('1);
		drain();
		write_reg(gmcr_pkg::CFG_STOP_A, 32'h00_000000);
		write_reg(gmcr_pkg::CFG_STOP_A + gmcr_pkg::IDX_W'(1), 32'hFF_FFFFFF);
		write_reg(gmcr_pkg::CFG_STOP_A + gmcr_pkg::IDX_W'(2), 32'h80_FF0000);
		write_reg(gmcr_pkg::CFG_STOP_A + gmcr_pkg::IDX_W'(3), 32'h80_00FF00);
		write_reg(gmcr_pkg::CFG_STOP_A + gmcr_pkg::IDX_W'(4), 32'h40_0000FF);
		for (int c = 2; c <= 7; c++) begin
			write_reg(gmcr_pkg::CFG_COUNT, 32'(c));
			send_pixel('0);
			send_pixel('1);
			send_pixel(24'h808080);
			drain();
		end
		// writes beyond the last register are ignored
		write_reg(gmcr_pkg::CFG_COUNT + gmcr_pkg::IDX_W'(1), 32'hFFFFFFFF);
		write_reg(gmcr_pkg::CFG_COUNT + gmcr_pkg::IDX_W'(2), 32'h12345678);
		send_pixel(24'h404040);
		drain();
		// random phases with the three idling regimes
		phases = 0;
		for (int p = 0; p < 27; p++) begin
			gap_pct = (p < 9) ? 6 : (p < 18) ? 88 : 0;
			load_ramp(p % 3, (p % 5 == 4) ? $urandom_range(7) : $urandom_range(5, 2));
			random_pixels(50);
			drain();
			phases++;
		end
		@(posedge clk);
		$display("checked %0d pixels over %0d random ramp settings plus directed cases",
			checked, phases);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

// ===== filelist.f =====
sv/gmcr_pkg.sv
sv/gradient_map_color_remap.sv
test/gmcr_checker.sv
test/testbench.sv
